// ===== src/kys_pkg.sv =====
// ---------------------------------------------------------------------------
// kys_pkg
// Shared types and constants of the Knuth-Yao Gaussian sampler.
// ---------------------------------------------------------------------------
package kys_pkg;

   localparam int VALUE_W = 6;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int ROW_W   = 5;
   localparam int DIST_W  = 8;
   localparam int BITS_W  = 32;
   localparam int CIDX_W  = 7;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_BIT  = 1'b1;

   typedef struct packed {
      logic accept_load;
      logic accept_bit;
      logic start_walk;
      logic capture;
      logic scan_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic awaiting_sign;
      logic scan_hit;
      logic scan_last_row;
      logic col_last;
      logic out_free;
   } status_type;

endpackage

// ===== src/kys_ram.sv =====
// ---------------------------------------------------------------------------
// kys_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kys_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/kys_ctrl.sv =====
// ---------------------------------------------------------------------------
// kys_ctrl
// Sequencer of the sampler: accepts words, runs column fetch, row scan and
// result hand-off.
// ---------------------------------------------------------------------------
module kys_ctrl
   import kys_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_ready && req_valid;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept_load = accept && (req_op == OP_LOAD);
            cmd.accept_bit  = accept && (req_op == OP_BIT);
            if (cmd.accept_bit) begin
               if (sts.awaiting_sign) begin
                  state_in = S_EMIT;
               end else begin
                  cmd.start_walk = 1'b1;
                  state_in       = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            cmd.capture = 1'b1;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            priority if (sts.scan_hit) begin
               state_in = S_IDLE;
            end else if (sts.scan_last_row) begin
               state_in = sts.col_last ? S_EMIT : S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_EMIT: begin
            cmd.emit = sts.out_free;
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/kys_datapath.sv =====
// ---------------------------------------------------------------------------
// kys_datapath
// Probability table, walk registers, bit-serial row scan, sample counter
// and output register of the sampler.
// ---------------------------------------------------------------------------
module kys_datapath
   import kys_pkg::*;
#(
   parameter int ROWS        = 32,
   parameter int COLS        = 128,
   parameter int MAX_SAMPLES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         sts,
   input  logic [CIDX_W-1:0]  column_index,
   input  logic [BITS_W-1:0]  column_bits,
   input  logic               random_bit,
   input  logic               csr_wen,
   input  logic [COUNT_W-1:0] csr_wdata,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] sample_value,
   output logic [INDEX_W-1:0] sample_index,
   output logic               last_of_poly,
   output logic               status
);

   localparam int AW        = $clog2(COLS);
   localparam int SCAN_ROWS = (ROWS < BITS_W) ? ROWS : BITS_W;
   localparam int SW        = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int EXT_W     = 17;
   localparam logic [ROW_W-1:0] TOP_ROW  = ROW_W'(SCAN_ROWS - 1);
   localparam logic [AW-1:0]    COL_LAST = AW'(COLS - 1);
   localparam logic [8:0]       COLS_EXT = 9'(COLS);
   localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_SAMPLES);

   logic [DIST_W-1:0]  distance_ff;
   logic [AW-1:0]      column_ff;
   logic               awaiting_ff;
   logic [ROW_W-1:0]   hit_row_ff;
   logic [SW-1:0]      counter_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [DIST_W:0]    t_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [BITS_W-1:0]  bits_ff;
   logic               bit_ff;
   logic               out_valid_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic               out_last_ff;
   logic               out_status_ff;

   logic [8:0]         idx_ext;
   logic               wr_en;
   logic [BITS_W-1:0]  rd_data;
   logic               row_bit;
   logic [DIST_W:0]    t_next;
   logic [DIST_W-1:0]  t_sat;
   logic [EXT_W-1:0]   count_eff;
   logic [EXT_W-1:0]   counter_ext;
   logic               is_last;
   logic [VALUE_W-1:0] signed_value;

   assign idx_ext = 9'(column_index);
   assign wr_en   = cmd.accept_load && (idx_ext < COLS_EXT);

   kys_ram #(
      .WIDTH(BITS_W),
      .DEPTH(COLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[AW-1:0]),
      .wr_data (column_bits),
      .rd_en   (cmd.start_walk),
      .rd_addr (column_ff),
      .rd_data (rd_data)
   );

   assign row_bit = bits_ff[row_ff];
   assign t_next  = t_ff - (DIST_W+1)'(row_bit);
   assign t_sat   = t_next[DIST_W] ? {DIST_W{1'b1}} : t_next[DIST_W-1:0];

   always_comb begin
      priority if (count_ff == '0) begin
         count_eff = EXT_W'(1);
      end else if (EXT_W'(count_ff) > MAX_EXT) begin
         count_eff = MAX_EXT;
      end else begin
         count_eff = EXT_W'(count_ff);
      end
   end

   assign counter_ext  = EXT_W'(counter_ff);
   assign is_last      = (counter_ext + EXT_W'(1)) >= count_eff;
   assign signed_value = bit_ff ? VALUE_W'(hit_row_ff)
                                : VALUE_W'(-VALUE_W'(hit_row_ff));

   assign sts.awaiting_sign = awaiting_ff;
   assign sts.scan_hit      = row_bit && (t_ff == '0);
   assign sts.scan_last_row = (row_ff == '0);
   assign sts.col_last      = (column_ff == COL_LAST);
   assign sts.out_free      = !out_valid_ff || rsp_ready;

   // walk and counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         distance_ff <= '0;
         column_ff   <= '0;
         awaiting_ff <= 1'b0;
         hit_row_ff  <= '0;
         counter_ff  <= '0;
         count_ff    <= COUNT_W'(256);
      end else begin
         if (csr_wen) begin
            count_ff <= csr_wdata;
         end
         if (cmd.scan_step) begin
            if (sts.scan_hit) begin
               hit_row_ff  <= row_ff;
               awaiting_ff <= 1'b1;
            end else if (sts.scan_last_row) begin
               if (sts.col_last) begin
                  distance_ff <= '0;
                  column_ff   <= '0;
               end else begin
                  distance_ff <= t_sat;
                  column_ff   <= column_ff + AW'(1);
               end
            end
         end
         if (cmd.emit && awaiting_ff) begin
            counter_ff  <= is_last ? '0 : counter_ff + SW'(1);
            awaiting_ff <= 1'b0;
            distance_ff <= '0;
            column_ff   <= '0;
            hit_row_ff  <= '0;
         end
      end
   end

   // scan working registers
   always_ff @(posedge clock) begin
      if (cmd.accept_bit) begin
         bit_ff <= random_bit;
      end
      if (cmd.start_walk) begin
         t_ff <= {distance_ff, ~random_bit};
      end
      if (cmd.capture) begin
         bits_ff <= rd_data;
         row_ff  <= TOP_ROW;
      end
      if (cmd.scan_step && !sts.scan_hit && !sts.scan_last_row) begin
         t_ff   <= t_next;
         row_ff <= row_ff - ROW_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_index_ff <= counter_ext[INDEX_W-1:0];
         if (awaiting_ff) begin
            out_value_ff  <= signed_value;
            out_last_ff   <= is_last;
            out_status_ff <= 1'b0;
         end else begin
            out_value_ff  <= '0;
            out_last_ff   <= 1'b0;
            out_status_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign sample_value = out_value_ff;
   assign sample_index = out_index_ff;
   assign last_of_poly = out_last_ff;
   assign status       = out_status_ff;

endmodule

// ===== src/knuth_yao_gaussian_sampler.sv =====
// ---------------------------------------------------------------------------
// knuth_yao_gaussian_sampler
// Knuth-Yao discrete Gaussian sampler fed by external random bits.
// ---------------------------------------------------------------------------
// Load words (tuser 0) write one column of the probability matrix; load the
// whole table before sending bit words. A walk bit (tuser 1) reads its
// column from the table RAM, captures it, then scans the rows from the top
// row down to the hit row or to row 0 (1 to min(ROWS, 32) rows); a walk that
// runs past the last column then hands off an overflow word. A sign bit
// yields the sample word. Results sit in an output register, so the next
// word is taken while a result waits; a second result waits in the block
// until the first is taken. sample_count is written through csr_wen /
// csr_wdata; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module knuth_yao_gaussian_sampler
   import kys_pkg::*;
#(
   parameter int ROWS        = 32,
   parameter int COLS        = 128,
   parameter int MAX_SAMPLES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // column_index [6:0], column_bits [38:7], random_bit [39]
   input  logic [REQ_W-1:0]   req_tdata,
   // op [0]
   input  logic               req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // sample_value [5:0], sample_index [15:6]
   output logic [RSP_W-1:0]   rsp_tdata,
   // status [0]
   output logic               rsp_tuser,
   output logic               rsp_tlast,
   input  logic               csr_wen,
   input  logic [COUNT_W-1:0] csr_wdata
);

   cmd_type            cmd;
   status_type         sts;
   logic [VALUE_W-1:0] sample_value;
   logic [INDEX_W-1:0] sample_index;

   kys_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kys_datapath #(
      .ROWS        (ROWS),
      .COLS        (COLS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .column_index (req_tdata[6:0]),
      .column_bits  (req_tdata[38:7]),
      .random_bit   (req_tdata[39]),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .sample_value (sample_value),
      .sample_index (sample_index),
      .last_of_poly (rsp_tlast),
      .status       (rsp_tuser)
   );

   assign rsp_tdata = {sample_index, sample_value};

`ifndef SYNTHESIS
   a_scan_not_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !sts.awaiting_sign)
      else $error("row scan while a sign bit is pending");

   a_sign_from_hit: assert property (@(posedge clock) disable iff (reset)
      $rose(sts.awaiting_sign) |-> $past(cmd.scan_step))
      else $error("pending sign set without a row hit");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over an untaken word");

   a_overflow_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tlast)
      else $error("overflow word flagged as last");
`endif

endmodule
